// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cmb_pkg.sv -----
package cmb_pkg;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	localparam logic REG_N_ELEMENTS = 1'b0;
	localparam logic REG_K_USED     = 1'b1;

	localparam int DIGIT_W = 8;
	localparam int POS_W   = 3;
	localparam int N_W     = 9;
	localparam int K_W     = 4;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FILL,
		CELL_CLEAR,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic [POS_W-1:0]   load_pos;
		logic [DIGIT_W-1:0] load_digit;
		logic [DIGIT_W-1:0] rot_digit;
		logic [POS_W-1:0]   best_pos;
		logic [DIGIT_W-1:0] best_val;
	} cell_ctl_t;

	typedef struct packed {
		logic           ok_out;
		logic           taken_out;
		logic           sel;
		logic [N_W-1:0] lo;
	} cell_stat_t;

endpackage

// ----- rtl/cmb_cell.sv -----
module cmb_cell #(
	parameter int IDX = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cmb_pkg::cell_ctl_t          ctl,
	input  logic [cmb_pkg::K_W-1:0]     k_eff,
	input  logic [cmb_pkg::N_W-1:0]     m_lim,
	input  logic [cmb_pkg::DIGIT_W-1:0] left_digit,
	input  logic                        ok_in,
	input  logic                        taken_in,
	output logic [cmb_pkg::DIGIT_W-1:0] digit,
	output cmb_pkg::cell_stat_t         stat
);

	logic [cmb_pkg::DIGIT_W-1:0] digit_q;
	logic [cmb_pkg::DIGIT_W-1:0] dmax;
	logic [cmb_pkg::N_W-1:0]     lo;
	logic [4:0]                  rem;
	logic                        in_use;
	logic                        cand;
	logic                        ok_self;
	logic                        eligible;
	logic                        fill_here;
	logic [cmb_pkg::DIGIT_W-1:0] fill_val;

	always_comb begin
		dmax      = (IDX > 0 && left_digit > digit_q) ? left_digit : digit_q;
		lo        = {1'b0, dmax} + 9'd1;
		in_use    = 5'(IDX) < {1'b0, k_eff};
		rem       = {1'b0, k_eff} - 5'(IDX + 1);
		cand      = in_use && (({1'b0, lo} + {5'b0, rem}) < {1'b0, m_lim});
		ok_self   = ({1'b0, digit_q} < m_lim) && (IDX == 0 || digit_q > left_digit);
		eligible  = cand && ok_in;
		fill_here = in_use && (5'(IDX) >= {2'b0, ctl.best_pos});
		fill_val  = ctl.best_val + 8'(IDX) - {5'b0, ctl.best_pos};
		stat.ok_out    = ok_in && ok_self;
		stat.taken_out = taken_in || eligible;
		stat.sel       = eligible && !taken_in;
		stat.lo        = lo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else begin
			case (ctl.op)
				cmb_pkg::CELL_LOAD: begin
					if (5'(IDX) == {2'b0, ctl.load_pos}) digit_q <= ctl.load_digit;
				end
				cmb_pkg::CELL_FILL: begin
					if (fill_here) digit_q <= fill_val;
				end
				cmb_pkg::CELL_CLEAR: begin
					digit_q <= '0;
				end
				cmb_pkg::CELL_ROTATE: begin
					if (in_use) digit_q <= ctl.rot_digit;
				end
				default: begin
					digit_q <= digit_q;
				end
			endcase
		end
	end

	assign digit = digit_q;

endmodule

// ----- rtl/combination_enumerator.sv -----
// Next strictly rising k-combination, lexicographic order.
// Command channel: an item is taken at a clock edge with start high and busy
// low. operation selects a digit load (digit_index, digit_value) or an advance.
// A load is written into its cell at the accepting edge, gives no result and leaves busy low.
// An advance runs: the EVAL state evaluates the cell row, the WRITE state writes the
// new tail (or clears every digit), then the EMIT state emits the digits. Results
// appear on position/digit/found/last with strobe high for one cycle each;
// the first result leaves the output registers after EVAL and WRITE, and busy falls
// with the final result, so a new item can be taken in that cycle.
// An advance keeps the block busy until its final result (k digits in use,
// or one result when exhausted); the single output port streams one digit
// per cycle from the head of the cell row.
// The receiver cannot hold results off: each is valid for exactly one cycle.
// Configuration: cfg_we/cfg_index/cfg_wdata write n_elements (index 0) or
// k_used (index 1); write only while busy is low.
// Reset: all digits clear to zero, n_elements = 8, k_used = 8, block idle.
`include "assert_macros.svh"

module combination_enumerator #(
	parameter int MAX_DIGITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        operation,
	input  logic [2:0]                  digit_index,
	input  logic [7:0]                  digit_value,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [8:0]                  cfg_wdata,
	output logic                        strobe,
	output logic [2:0]                  position,
	output logic [7:0]                  digit,
	output logic                        found,
	output logic                        last
);

	// Digits in use never exceed eight, nor the number of cells
	localparam int KCAP = (MAX_DIGITS < 8) ? MAX_DIGITS : 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_WRITE,
		ST_EMIT
	} state_t;

	state_t                          state_q;
	logic [cmb_pkg::N_W-1:0]         n_q;
	logic [cmb_pkg::K_W-1:0]         k_q;
	logic [cmb_pkg::K_W-1:0]         k_eff;
	logic [cmb_pkg::N_W-1:0]         m_lim;
	logic                            found_q;
	logic [cmb_pkg::POS_W-1:0]       best_pos_q;
	logic [cmb_pkg::DIGIT_W-1:0]     best_val_q;
	logic [cmb_pkg::POS_W-1:0]       cnt_q;
	logic                            strobe_q;
	logic [cmb_pkg::POS_W-1:0]       position_q;
	logic [cmb_pkg::DIGIT_W-1:0]     digit_q;
	logic                            found_out_q;
	logic                            last_q;

	logic [cmb_pkg::POS_W-1:0]       best_pos;
	logic [cmb_pkg::DIGIT_W-1:0]     best_val;
	logic                            any_found;
	logic                            emit_last;
	logic                            take_load;
	logic                            take_adv;
	cmb_pkg::cell_op_t               row_op;

	cmb_pkg::cell_ctl_t              ctl     [MAX_DIGITS];
	cmb_pkg::cell_stat_t             stat    [MAX_DIGITS];
	logic [cmb_pkg::DIGIT_W-1:0]     cell_d  [MAX_DIGITS];
	logic [MAX_DIGITS:0]             ok_c;
	logic [MAX_DIGITS:0]             taken_c;

	assign busy      = (state_q != ST_IDLE);
	assign take_load = start && !busy && (operation == cmb_pkg::OP_LOAD);
	assign take_adv  = start && !busy && (operation == cmb_pkg::OP_ADVANCE);

	// Clamp the live configuration
	assign k_eff = (k_q > 4'(KCAP)) ? 4'(KCAP) : k_q;
	assign m_lim = (n_q > 9'd256) ? 9'd256 : n_q;

	assign emit_last = ({1'b0, cnt_q} + 4'd1) == k_eff;

	// Prefix validity runs rightwards, the deepest-candidate claim runs leftwards
	assign ok_c[0]             = 1'b1;
	assign taken_c[MAX_DIGITS] = 1'b0;
	assign any_found           = taken_c[0];

	// Pick out the one selected cell: its position and its starting value
	always_comb begin
		best_pos = '0;
		best_val = '0;
		for (int p = 0; p < MAX_DIGITS; p++) begin
			if (stat[p].sel) begin
				best_pos = best_pos | 3'(p);
				best_val = best_val | stat[p].lo[7:0];
			end
		end
	end

	// Operation broadcast to the whole row this cycle
	always_comb begin
		row_op = cmb_pkg::CELL_HOLD;
		case (state_q)
			ST_IDLE:  if (take_load) row_op = cmb_pkg::CELL_LOAD;
			ST_WRITE: row_op = found_q ? cmb_pkg::CELL_FILL : cmb_pkg::CELL_CLEAR;
			ST_EMIT:  if (found_q) row_op = cmb_pkg::CELL_ROTATE;
			default:  row_op = cmb_pkg::CELL_HOLD;
		endcase
	end

	for (genvar p = 0; p < MAX_DIGITS; p++) begin : g_cell
		localparam int NXT = (p + 1 < MAX_DIGITS) ? p + 1 : 0;

		// The cell at the end of the used span takes the head digit back
		always_comb begin
			ctl[p].op         = row_op;
			ctl[p].load_pos   = digit_index;
			ctl[p].load_digit = digit_value;
			ctl[p].rot_digit  = ({1'b0, k_eff} == 5'(p + 1)) ? cell_d[0] : cell_d[NXT];
			ctl[p].best_pos   = best_pos_q;
			ctl[p].best_val   = best_val_q;
		end

		cmb_cell #(
			.IDX (p)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl[p]),
			.k_eff      (k_eff),
			.m_lim      (m_lim),
			.left_digit ((p == 0) ? 8'd0 : cell_d[(p == 0) ? 0 : p - 1]),
			.ok_in      (ok_c[p]),
			.taken_in   (taken_c[p + 1]),
			.digit      (cell_d[p]),
			.stat       (stat[p])
		);

		assign ok_c[p + 1] = stat[p].ok_out;
		assign taken_c[p]  = stat[p].taken_out;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= 9'd8;
			k_q <= 4'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				cmb_pkg::REG_N_ELEMENTS: n_q <= cfg_wdata;
				cmb_pkg::REG_K_USED:     k_q <= cfg_wdata[3:0];
				default:                 n_q <= n_q;
			endcase
		end
	end

	// Sequencer and registered result port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			found_q     <= 1'b0;
			best_pos_q  <= '0;
			best_val_q  <= '0;
			cnt_q       <= '0;
			strobe_q    <= 1'b0;
			position_q  <= '0;
			digit_q     <= '0;
			found_out_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take_adv) state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					// Latch the winning cell; the row is written next cycle
					found_q    <= any_found;
					best_pos_q <= best_pos;
					best_val_q <= best_val;
					state_q    <= ST_WRITE;
				end
				ST_WRITE: begin
					cnt_q   <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					if (found_q) begin
						// Stream the head cell while the used span rotates
						position_q  <= cnt_q;
						digit_q     <= cell_d[0];
						found_out_q <= 1'b1;
						last_q      <= emit_last;
						cnt_q       <= cnt_q + 3'd1;
						if (emit_last) state_q <= ST_IDLE;
					end else begin
						// Exhausted: one marker result, store already cleared
						position_q  <= '0;
						digit_q     <= '0;
						found_out_q <= 1'b0;
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe   = strobe_q;
	assign position = position_q;
	assign digit    = digit_q;
	assign found    = found_out_q;
	assign last     = last_q;

	`ASSERT_CLK(a_strobe_from_emit, clk, arst_n, strobe |-> $past(state_q == ST_EMIT), "result outside emit")
	`ASSERT_CLK(a_exhausted_is_last, clk, arst_n, (strobe && !found) |-> last, "exhausted result not last")
	`ASSERT_CLK(a_done_with_last, clk, arst_n, $fell(busy) |-> (strobe && last), "busy dropped without last result")
	`ASSERT_CLK(a_advance_goes_busy, clk, arst_n, take_adv |=> (state_q == ST_EVAL), "advance not started")

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the next rising k-combination block.
// A driver feeds load and advance commands from a queue; a monitor mirrors the
// digit store, predicts every emitted digit and checks each result strobe.
module testbench;

	localparam int MAX_DIGITS  = 8;
	localparam int SETTLE_CYC  = 12;   // settling margin after a phase drains
	localparam int STALL_LIMIT = 400;  // cycles with no transaction of any kind
	localparam int PHASE_ITEMS = 16;
	localparam int REPORT_CAP  = 40;

	// One command transaction
	typedef struct packed {
		logic                        op;
		logic [cmb_pkg::POS_W-1:0]   idx;
		logic [cmb_pkg::DIGIT_W-1:0] val;
	} digit_cmd_t;

	// One emitted digit as the block should present it
	typedef struct packed {
		logic [cmb_pkg::POS_W-1:0]   pos;
		logic [cmb_pkg::DIGIT_W-1:0] dig;
		logic                        fnd;
		logic                        lst;
	} digit_result_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               start       = 1'b0;
	logic               operation   = cmb_pkg::OP_LOAD;
	logic [2:0]         digit_index = '0;
	logic [7:0]         digit_value = '0;
	logic               cfg_we      = 1'b0;
	logic               cfg_index   = cmb_pkg::REG_N_ELEMENTS;
	logic [8:0]         cfg_wdata   = '0;
	logic               busy;
	logic               strobe;
	logic [2:0]         position;
	logic [7:0]         digit;
	logic               found;
	logic               last;

	digit_cmd_t    cmd_queue[$];
	digit_result_t digits_due[$];

	// Mirror of the block: digit store and both registers, at reset values
	logic [cmb_pkg::DIGIT_W-1:0] stored_digits [MAX_DIGITS] = '{default: '0};
	logic [cmb_pkg::N_W-1:0]     set_size = 9'd8;
	logic [cmb_pkg::K_W-1:0]     k_count  = 4'd8;

	int unsigned n_issued    = 0;
	int unsigned n_taken     = 0;
	int unsigned n_errors    = 0;
	int unsigned gap_left    = 0;
	int unsigned idle_cycles = 0;
	bit          gapless     = 1'b0;

	combination_enumerator #(
		.MAX_DIGITS(MAX_DIGITS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.digit_index(digit_index),
		.digit_value(digit_value),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.strobe     (strobe),
		.position   (position),
		.digit      (digit),
		.found      (found),
		.last       (last)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(string msg);
		n_errors++;
		if (n_errors <= REPORT_CAP) begin
			$display("%0t ns: %s", $time, msg);
		end
	endtask

	// Find the smallest strictly rising tuple above the stored one and queue its
	// digits; with none available, clear the store and queue the exhausted marker.
	function automatic void next_combination();
		int unsigned k_eff;
		int unsigned limit;
		int unsigned floor_v;
		int unsigned fill_v;
		int          pivot;
		bit          prefix_rising;
		k_eff         = (k_count > MAX_DIGITS) ? MAX_DIGITS : k_count;
		limit         = (set_size > 256) ? 256 : set_size;
		pivot         = -1;
		fill_v        = 0;
		prefix_rising = 1'b1;
		// Try every position whose prefix is already a valid rising run; the
		// deepest one that still leaves room for the tail gives the smallest answer.
		for (int p = 0; p < k_eff && prefix_rising; p++) begin
			floor_v = stored_digits[p] + 1;
			if (p > 0 && stored_digits[p-1] + 1 > floor_v) begin
				floor_v = stored_digits[p-1] + 1;
			end
			if (floor_v + (k_eff - 1 - p) < limit) begin
				pivot  = p;
				fill_v = floor_v;
			end
			prefix_rising = (stored_digits[p] < limit) &&
				(p == 0 || stored_digits[p] > stored_digits[p-1]);
		end
		if (pivot < 0) begin
			stored_digits = '{default: '0};
			digits_due.push_back('{pos: '0, dig: '0, fnd: 1'b0, lst: 1'b1});
		end else begin
			for (int p = pivot; p < k_eff; p++) begin
				stored_digits[p] = fill_v[cmb_pkg::DIGIT_W-1:0];
				fill_v++;
			end
			for (int p = 0; p < k_eff; p++) begin
				digits_due.push_back('{pos: p[cmb_pkg::POS_W-1:0], dig: stored_digits[p],
					fnd: 1'b1, lst: (p + 1 == k_eff)});
			end
		end
	endfunction

	// Monitor: track register writes, check result strobes, predict on acceptance
	always @(posedge clk) begin : monitor
		digit_result_t want;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == cmb_pkg::REG_N_ELEMENTS) begin
					set_size = cfg_wdata;
				end else begin
					k_count = cfg_wdata[cmb_pkg::K_W-1:0];
				end
			end
			if (strobe) begin
				if (digits_due.size() == 0) begin
					report_mismatch($sformatf(
						"unexpected result pos=%0d digit=%0d found=%0b last=%0b",
						position, digit, found, last));
				end else begin
					want = digits_due.pop_front();
					if (position !== want.pos) begin
						report_mismatch($sformatf("position: got %0d, expected %0d",
							position, want.pos));
					end
					if (digit !== want.dig) begin
						report_mismatch($sformatf("digit at %0d: got %0d, expected %0d",
							want.pos, digit, want.dig));
					end
					if (found !== want.fnd) begin
						report_mismatch($sformatf("found: got %0b, expected %0b",
							found, want.fnd));
					end
					if (last !== want.lst) begin
						report_mismatch($sformatf("last at %0d: got %0b, expected %0b",
							want.pos, last, want.lst));
					end
				end
			end
			// Results are checked before the new command is predicted: the final
			// digit of one advance may share its edge with the next acceptance.
			if (start && !busy) begin
				n_taken++;
				if (operation == cmb_pkg::OP_ADVANCE) begin
					next_combination();
				end else begin
					stored_digits[digit_index] = digit_value;
				end
			end
		end
	end

	// Driver: hold start until the transaction is taken, then idle for the drawn
	// gap before presenting the next command.
	always @(negedge clk) begin : driver
		digit_cmd_t cmd;
		if (arst_n && !(start && n_taken != n_issued)) begin
			if (gap_left != 0) begin
				start <= 1'b0;
				gap_left--;
			end else if (cmd_queue.size() != 0) begin
				cmd = cmd_queue.pop_front();
				operation   <= cmd.op;
				digit_index <= cmd.idx;
				digit_value <= cmd.val;
				start       <= 1'b1;
				n_issued++;
				gap_left = gapless ? 0 : $urandom_range(0, 15);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Watchdog: any command, result or register write counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe || cfg_we) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic void push_cmd(logic op, int unsigned idx, int unsigned val);
		cmd_queue.push_back('{op: op, idx: idx[cmb_pkg::POS_W-1:0],
			val: val[cmb_pkg::DIGIT_W-1:0]});
	endfunction

	// Mostly well-formed runs (a full rising tuple loaded, then several advances),
	// with some broken runs of stray loads and some raw noise.
	task automatic queue_random(int unsigned total, int unsigned n_val, int unsigned k_val);
		int unsigned made;
		int unsigned m_eff;
		int unsigned k_eff;
		int unsigned v;
		int unsigned reps;
		made  = 0;
		m_eff = (n_val > 256) ? 256 : n_val;
		k_eff = (k_val > MAX_DIGITS) ? MAX_DIGITS : k_val;
		while (made < total) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					push_cmd($urandom_range(0, 1) ? cmb_pkg::OP_ADVANCE : cmb_pkg::OP_LOAD,
						$urandom_range(0, 7), $urandom_range(0, 255));
					made++;
				end
				2: begin
					reps = $urandom_range(1, 3);
					repeat (reps) begin
						push_cmd(cmb_pkg::OP_LOAD, $urandom_range(0, 7),
							$urandom_range(0, 255));
					end
					push_cmd(cmb_pkg::OP_ADVANCE, $urandom_range(0, 7), $urandom_range(0, 255));
					made += reps + 1;
				end
				default: begin
					v = $urandom_range(0, m_eff);
					// Load the tail beyond k now and then, so unused digits move too
					reps = $urandom_range(0, 3) == 0 ? MAX_DIGITS : (k_eff == 0 ? 1 : k_eff);
					for (int p = 0; p < reps; p++) begin
						push_cmd(cmb_pkg::OP_LOAD, p, v);
						v += ($urandom_range(0, 3) == 0) ? 2 : 1;
					end
					made += reps;
					reps = $urandom_range(1, 6);
					repeat (reps) begin
						push_cmd(cmb_pkg::OP_ADVANCE, $urandom_range(0, 7),
							$urandom_range(0, 255));
					end
					made += reps;
				end
			endcase
		end
	endtask

	// Wait until every command is taken and every digit has come out, then let
	// the block settle before anything else touches it.
	task automatic drain();
		while (cmd_queue.size() != 0 || n_taken != n_issued || digits_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_config(int unsigned n_val, int unsigned k_val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = cmb_pkg::REG_N_ELEMENTS;
		cfg_wdata = n_val[cmb_pkg::N_W-1:0];
		@(negedge clk);
		cfg_index = cmb_pkg::REG_K_USED;
		cfg_wdata = k_val[8:0];
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// Register settings per phase: extremes, out-of-range sizes, zero counts
	int unsigned n_list [10] = '{10, 1, 256, 0, 511, 5, 12, 256, 20, 6};
	int unsigned k_list [10] = '{3, 1, 8, 4, 2, 0, 15, 1, 5, 6};

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed run at reset settings (eight of eight)
		push_cmd(cmb_pkg::OP_ADVANCE, 0, 0);      // zeros: not rising, gives 0..7
		push_cmd(cmb_pkg::OP_ADVANCE, 7, 255);    // nothing above 0..7: exhausted
		push_cmd(cmb_pkg::OP_ADVANCE, 0, 0);      // store cleared, so 0..7 again
		push_cmd(cmb_pkg::OP_LOAD, 0, 255);       // head digit far above the set size
		push_cmd(cmb_pkg::OP_LOAD, 7, 0);
		push_cmd(cmb_pkg::OP_ADVANCE, 0, 0);
		for (int p = 0; p < MAX_DIGITS; p++) begin
			push_cmd(cmb_pkg::OP_LOAD, p, (p == 7) ? 6 : p);   // tail digit repeats its neighbour
		end
		push_cmd(cmb_pkg::OP_ADVANCE, 0, 0);
		push_cmd(cmb_pkg::OP_LOAD, 3, 200);       // out-of-range digit in the middle
		push_cmd(cmb_pkg::OP_LOAD, 5, 8'hAA);
		push_cmd(cmb_pkg::OP_LOAD, 6, 8'h55);
		push_cmd(cmb_pkg::OP_ADVANCE, 0, 0);
		queue_random(PHASE_ITEMS, 8, 8);
		drain();

		foreach (n_list[i]) begin
			write_config(n_list[i], k_list[i]);
			gapless = (i % 3 == 1);
			queue_random(PHASE_ITEMS, n_list[i], k_list[i]);
			drain();
		end

		if (n_errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/cmb_pkg.sv
rtl/cmb_cell.sv
rtl/combination_enumerator.sv
tb/testbench.sv
